[hdl/cspmv_pkg.sv]
// Shared types and constants for the complex COO sparse matrix-vector multiplier.
package cspmv_pkg;

    localparam int ROW_BITS   = 10;
    localparam int COL_BITS   = 10;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int FIFO_CW    = 5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                fin;
        logic [ROW_BITS-1:0] row;
    } ctl_t;

    typedef struct packed {
        logic a;
        logic b;
    } push_t;

endpackage

[hdl/coo_sparse_matrix_vector_multiply.sv]
// Top level of the complex COO sparse matrix times dense vector engine.
// Input channel (item_valid / item_stall): cmd = load writes one complex element
// of the dense vector; cmd = entry carries a matrix nonzero (row, col, value).
// Output channel (result_valid / result_stall): one row sum per transaction,
// last_of_run marks the final result caused by one input transaction.
// Throughput: one input transaction per cycle when item_stall is low, set by the
// single-port vector RAM (one write or one read per cycle) and one complex
// multiply per cycle. Entries that cause two results outpace a receiver
// taking one per cycle; the queue then fills and item_stall throttles the input.
// A result passes the RAM read, product, combine and accumulate-into-queue
// registers in that order after the edge that accepts the entry causing it,
// and once it is on the output it can be taken at the next edge.
// A row sum is emitted when an entry of a different row arrives or when an
// entry with final_entry set is accumulated; one entry may cause two results.
// Results wait in a 16-deep queue. item_stall rises when the queue plus the
// entries in flight could overflow it; a stalled output holds its transaction.
// Reset clears the pipeline, the open row and the queue; the vector RAM keeps
// whatever it holds and must be loaded before use.
module coo_sparse_matrix_vector_multiply #(
    parameter int VEC_DEPTH  = 1024,
    parameter int VALUE_BITS = 16,
    parameter int ACC_BITS   = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                cmd,
    input  logic [cspmv_pkg::COL_BITS-1:0]      col_index,
    input  logic [cspmv_pkg::ROW_BITS-1:0]      row_index,
    input  logic signed [VALUE_BITS-1:0]        value_re,
    input  logic signed [VALUE_BITS-1:0]        value_im,
    input  logic                                final_entry,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [cspmv_pkg::ROW_BITS-1:0]      out_row,
    output logic signed [ACC_BITS-1:0]          sum_re,
    output logic signed [ACC_BITS-1:0]          sum_im,
    output logic                                last_of_run
);

    import cspmv_pkg::*;

    localparam int AW = $clog2(VEC_DEPTH);

    logic                       accept, col_ok, we;
    logic [AW-1:0]              addr;
    logic [2*VALUE_BITS-1:0]    rdata;
    ctl_t                       ctl_in, ctl3;
    logic signed [ACC_BITS-1:0] pre, pim;
    logic [2:0]                 stage_valid;
    push_t                      push;
    logic [ROW_BITS-1:0]        a_row, b_row;
    logic signed [ACC_BITS-1:0] a_re, a_im, b_re, b_im;
    logic                       a_last;
    logic [FIFO_CW-1:0]         count, need;

    always_comb
    begin
        accept        = item_valid && !item_stall;
        col_ok        = 32'(col_index) < 32'(VEC_DEPTH);
        addr          = AW'(col_index);
        we            = accept && (cmd == CMD_LOAD) && col_ok;
        ctl_in.valid  = accept && (cmd == CMD_ENTRY);
        ctl_in.fin    = final_entry;
        ctl_in.row    = row_index;
        need          = count
                      + FIFO_CW'({stage_valid[2], 1'b0})
                      + FIFO_CW'({stage_valid[1], 1'b0})
                      + FIFO_CW'({stage_valid[0], 1'b0})
                      + FIFO_CW'(2);
        item_stall    = need > FIFO_CW'(FIFO_DEPTH);
    end

    cspmv_vec_store #(
        .VEC_DEPTH  (VEC_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata ({value_im, value_re}),
        .rdata (rdata)
    );

    cspmv_cmac #(
        .VALUE_BITS (VALUE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_cmac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (ctl_in),
        .col_ok      (col_ok),
        .a_re        (value_re),
        .a_im        (value_im),
        .rdata       (rdata),
        .ctl_out     (ctl3),
        .pre         (pre),
        .pim         (pim),
        .stage_valid (stage_valid)
    );

    cspmv_row_acc #(
        .ACC_BITS (ACC_BITS)
    ) u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl3),
        .pre    (pre),
        .pim    (pim),
        .push   (push),
        .a_row  (a_row),
        .a_re   (a_re),
        .a_im   (a_im),
        .a_last (a_last),
        .b_row  (b_row),
        .b_re   (b_re),
        .b_im   (b_im)
    );

    cspmv_out_fifo #(
        .ACC_BITS (ACC_BITS)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .a_row       (a_row),
        .a_re        (a_re),
        .a_im        (a_im),
        .a_last      (a_last),
        .b_row       (b_row),
        .b_re        (b_re),
        .b_im        (b_im),
        .stall       (result_stall),
        .valid       (result_valid),
        .out_row     (out_row),
        .sum_re      (sum_re),
        .sum_im      (sum_im),
        .last_of_run (last_of_run),
        .count       (count)
    );

endmodule

[hdl/cspmv_vec_store.sv]
// Dense vector store: single-port synchronous RAM with registered read data.
module cspmv_vec_store #(
    parameter int VEC_DEPTH  = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(VEC_DEPTH)-1:0]  addr,
    input  logic [2*VALUE_BITS-1:0]       wdata,
    output logic [2*VALUE_BITS-1:0]       rdata
);

    logic [2*VALUE_BITS-1:0] mem [VEC_DEPTH];
    logic [2*VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cspmv_cmac.sv]
// Complex multiply pipeline: partial products, then saturating combine.
module cspmv_cmac #(
    parameter int VALUE_BITS = 16,
    parameter int ACC_BITS   = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cspmv_pkg::ctl_t               ctl_in,
    input  logic                          col_ok,
    input  logic signed [VALUE_BITS-1:0]  a_re,
    input  logic signed [VALUE_BITS-1:0]  a_im,
    input  logic [2*VALUE_BITS-1:0]       rdata,
    output cspmv_pkg::ctl_t               ctl_out,
    output logic signed [ACC_BITS-1:0]    pre,
    output logic signed [ACC_BITS-1:0]    pim,
    output logic [2:0]                    stage_valid
);

    import cspmv_pkg::*;

    localparam int PW = 2 * VALUE_BITS;
    localparam int SW = ((PW > ACC_BITS) ? PW : ACC_BITS) + 2;
    localparam logic signed [SW-1:0] ACC_MAX = {{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SW-1:0] x);
        logic signed [ACC_BITS-1:0] r;
        if (x > ACC_MAX)
        begin
            r = ACC_MAX[ACC_BITS-1:0];
        end
        else if (x < ACC_MIN)
        begin
            r = ACC_MIN[ACC_BITS-1:0];
        end
        else
        begin
            r = x[ACC_BITS-1:0];
        end
        return r;
    endfunction

    ctl_t                        ctl1_reg, ctl2_reg, ctl3_reg;
    logic                        col_ok_reg;
    logic signed [VALUE_BITS-1:0] a_re_reg, a_im_reg;
    logic signed [VALUE_BITS-1:0] b_re, b_im;
    logic signed [PW-1:0]        p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0]        p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic signed [ACC_BITS-1:0]  pre_reg, pim_reg, pre_next, pim_next;

    always_comb
    begin
        b_re      = col_ok_reg ? rdata[VALUE_BITS-1:0] : '0;
        b_im      = col_ok_reg ? rdata[2*VALUE_BITS-1:VALUE_BITS] : '0;
        p_rr_next = a_re_reg * b_re;
        p_ii_next = a_im_reg * b_im;
        p_ri_next = a_re_reg * b_im;
        p_ir_next = a_im_reg * b_re;
    end

    always_comb
    begin
        pre_next = sat_acc(SW'(sat_acc(SW'(p_rr_reg))) - SW'(p_ii_reg));
        pim_next = sat_acc(SW'(sat_acc(SW'(p_ri_reg))) + SW'(p_ir_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col_ok_reg <= col_ok;
        a_re_reg   <= a_re;
        a_im_reg   <= a_im;
        p_rr_reg   <= p_rr_next;
        p_ii_reg   <= p_ii_next;
        p_ri_reg   <= p_ri_next;
        p_ir_reg   <= p_ir_next;
        pre_reg    <= pre_next;
        pim_reg    <= pim_next;
    end

    assign ctl_out     = ctl3_reg;
    assign pre         = pre_reg;
    assign pim         = pim_reg;
    assign stage_valid = {ctl1_reg.valid, ctl2_reg.valid, ctl3_reg.valid};

endmodule

[hdl/cspmv_row_acc.sv]
// Row accumulator: saturating complex sum, emits on row change and final entry.
module cspmv_row_acc #(
    parameter int ACC_BITS = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cspmv_pkg::ctl_t                     ctl,
    input  logic signed [ACC_BITS-1:0]          pre,
    input  logic signed [ACC_BITS-1:0]          pim,
    output cspmv_pkg::push_t                    push,
    output logic [cspmv_pkg::ROW_BITS-1:0]      a_row,
    output logic signed [ACC_BITS-1:0]          a_re,
    output logic signed [ACC_BITS-1:0]          a_im,
    output logic                                a_last,
    output logic [cspmv_pkg::ROW_BITS-1:0]      b_row,
    output logic signed [ACC_BITS-1:0]          b_re,
    output logic signed [ACC_BITS-1:0]          b_im
);

    import cspmv_pkg::*;

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] x,
        input logic signed [ACC_BITS-1:0] y
    );
        logic signed [ACC_BITS:0] s;
        logic signed [ACC_BITS-1:0] r;
        s = {x[ACC_BITS-1], x} + {y[ACC_BITS-1], y};
        if (s[ACC_BITS] != s[ACC_BITS-1])
        begin
            r = {s[ACC_BITS], {(ACC_BITS-1){~s[ACC_BITS]}}};
        end
        else
        begin
            r = s[ACC_BITS-1:0];
        end
        return r;
    endfunction

    logic [ROW_BITS-1:0]        open_row_reg, open_row_next;
    logic                       active_reg, active_next;
    logic signed [ACC_BITS-1:0] acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic                       change;
    logic signed [ACC_BITS-1:0] new_re, new_im;

    always_comb
    begin
        change        = ctl.valid && active_reg && (ctl.row != open_row_reg);
        new_re        = sat_add(change ? '0 : acc_re_reg, pre);
        new_im        = sat_add(change ? '0 : acc_im_reg, pim);
        open_row_next = open_row_reg;
        active_next   = active_reg;
        acc_re_next   = acc_re_reg;
        acc_im_next   = acc_im_reg;
        if (ctl.valid)
        begin
            open_row_next = ctl.row;
            active_next   = !ctl.fin;
            acc_re_next   = ctl.fin ? '0 : new_re;
            acc_im_next   = ctl.fin ? '0 : new_im;
        end
        push.a = change;
        push.b = ctl.valid && ctl.fin;
        a_row  = open_row_reg;
        a_re   = acc_re_reg;
        a_im   = acc_im_reg;
        a_last = !ctl.fin;
        b_row  = ctl.row;
        b_re   = new_re;
        b_im   = new_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_row_reg <= '0;
            active_reg   <= 1'b0;
            acc_re_reg   <= '0;
            acc_im_reg   <= '0;
        end
        else
        begin
            open_row_reg <= open_row_next;
            active_reg   <= active_next;
            acc_re_reg   <= acc_re_next;
            acc_im_reg   <= acc_im_next;
        end
    end

endmodule

[hdl/cspmv_out_fifo.sv]
// Result queue: up to two writes per cycle, one read per cycle unless stall is high.
module cspmv_out_fifo #(
    parameter int ACC_BITS = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cspmv_pkg::push_t                    push,
    input  logic [cspmv_pkg::ROW_BITS-1:0]      a_row,
    input  logic signed [ACC_BITS-1:0]          a_re,
    input  logic signed [ACC_BITS-1:0]          a_im,
    input  logic                                a_last,
    input  logic [cspmv_pkg::ROW_BITS-1:0]      b_row,
    input  logic signed [ACC_BITS-1:0]          b_re,
    input  logic signed [ACC_BITS-1:0]          b_im,
    input  logic                                stall,
    output logic                                valid,
    output logic [cspmv_pkg::ROW_BITS-1:0]      out_row,
    output logic signed [ACC_BITS-1:0]          sum_re,
    output logic signed [ACC_BITS-1:0]          sum_im,
    output logic                                last_of_run,
    output logic [cspmv_pkg::FIFO_CW-1:0]       count
);

    import cspmv_pkg::*;

    logic [ROW_BITS-1:0]        row_mem  [FIFO_DEPTH];
    logic [ACC_BITS-1:0]        re_mem   [FIFO_DEPTH];
    logic [ACC_BITS-1:0]        im_mem   [FIFO_DEPTH];
    logic                       last_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]         head_reg, head_next, tail_reg, tail_next, b_idx;
    logic [FIFO_CW-1:0]         count_reg, count_next;
    logic                       pop;

    always_comb
    begin
        pop        = (count_reg != '0) && !stall;
        b_idx      = tail_reg + FIFO_AW'(push.a);
        head_next  = head_reg + FIFO_AW'(pop);
        tail_next  = tail_reg + FIFO_AW'(push.a) + FIFO_AW'(push.b);
        count_next = count_reg + FIFO_CW'(push.a) + FIFO_CW'(push.b) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.a)
        begin
            row_mem[tail_reg]  <= a_row;
            re_mem[tail_reg]   <= a_re;
            im_mem[tail_reg]   <= a_im;
            last_mem[tail_reg] <= a_last;
        end
        if (push.b)
        begin
            row_mem[b_idx]  <= b_row;
            re_mem[b_idx]   <= b_re;
            im_mem[b_idx]   <= b_im;
            last_mem[b_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign valid       = (count_reg != '0);
    assign out_row     = row_mem[head_reg];
    assign sum_re      = re_mem[head_reg];
    assign sum_im      = im_mem[head_reg];
    assign last_of_run = last_mem[head_reg];
    assign count       = count_reg;

endmodule

[hdl/cspmv_checker.sv]
// Port-level checker for the sparse matrix-vector engine, bound to the top level.
module cspmv_checker #(
    parameter int ACC_BITS   = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  logic                                cmd,
    input  logic                                final_entry,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic [cspmv_pkg::ROW_BITS-1:0]      out_row,
    input  logic signed [ACC_BITS-1:0]          sum_re,
    input  logic signed [ACC_BITS-1:0]          sum_im,
    input  logic                                last_of_run
);

    import cspmv_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_row)
            && $stable(sum_re) && $stable(sum_im) && $stable(last_of_run))
        else $error("stalled result changed");

    // a final entry reaches the output within the pipeline latency
    a_final_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (cmd == CMD_ENTRY) && final_entry
            |-> ##4 result_valid)
        else $error("final entry produced no result in time");

    // a result that is not last of its run is followed by its partner
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last_of_run |=> result_valid)
        else $error("row-change result not followed by its pair");

    // a load alone never produces output from an idle block
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && item_valid && !item_stall && (cmd == CMD_LOAD)
            ##1 !result_valid ##1 !result_valid ##1 !result_valid
            |=> !result_valid)
        else $error("load produced a result");

endmodule

bind coo_sparse_matrix_vector_multiply cspmv_checker #(
    .ACC_BITS   (ACC_BITS)
) u_cspmv_checker (.*);
